// ----- design/btql_pkg.sv -----
// shared types, codes and helpers for the bitmap text quad layout core
package btql_pkg;

	typedef enum logic [1:0] {
		ACT_WRITE_GLYPH = 2'd0,
		ACT_BEGIN       = 2'd1,
		ACT_LAYOUT      = 2'd2,
		ACT_UNUSED      = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		CFG_SPACE_WIDTH = 3'd0,
		CFG_TAB_WIDTH   = 3'd1,
		CFG_LINE_SKIP   = 3'd2,
		CFG_ORIGIN_X    = 3'd3,
		CFG_ORIGIN_Y    = 3'd4
	} cfg_index_t;

	typedef enum logic [2:0] {
		KIND_BEGIN,
		KIND_SPACE,
		KIND_TAB,
		KIND_NEWLINE,
		KIND_GLYPH,
		KIND_NONE
	} char_kind_t;

	localparam logic [7:0] CH_SPACE   = 8'd32;
	localparam logic [7:0] CH_TAB     = 8'd9;
	localparam logic [7:0] CH_NEWLINE = 8'd10;

	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 136;

	typedef struct packed {
		logic [7:0]        advance;
		logic signed [7:0] x_bearing;
		logic signed [7:0] y_offset;
		logic [7:0]        width;
		logic [7:0]        height;
		logic [7:0]        atlas_u;
		logic [7:0]        atlas_v;
	} glyph_t;

	function automatic logic [15:0] sat_u16(input logic [16:0] v);
		sat_u16 = v[16] ? 16'hFFFF : v[15:0];
	endfunction

	function automatic logic signed [15:0] sat_s16(input logic signed [18:0] v);
		if (v > 19'sd32767) begin
			sat_s16 = 16'sh7FFF;
		end else if (v < -19'sd32768) begin
			sat_s16 = 16'sh8000;
		end else begin
			sat_s16 = v[15:0];
		end
	endfunction

endpackage

// ----- design/bitmap_text_quad_layout_core.sv -----
// bitmap text quad layout core: glyph table memory, pen tracking and quad output
//
// input items arrive on s_axis; s_axis_tuser carries the action (write glyph entry,
// begin string, lay out character). a glyph write stores one table entry and gives
// no item out; begin clears the pen and the measures and gives no item out. every
// lay-out action gives exactly one item on m_axis with the screen and atlas
// rectangles (m_axis_tuser is quad_valid) and the running text width and height.
// configuration registers are written on the cfg channel; the user must write them only
// while the core is idle, and the core does not enforce this. cfg_ready is always high.
// one item is taken per cycle while s_axis_tready is high. after the accepting edge
// registers the glyph table read, stage 2 registers the pen update and rectangle
// sums, then the saturated output register drives m_axis_tvalid.
// the pen registers feed their own next-state logic directly, so back-to-back
// characters need no bubble.
// when m_axis_tready is low the output register holds; the stages behind it keep
// filling until occupied, then s_axis_tready drops.
// arst_n clears the pipeline valids, the pen, the measures and the configuration
// registers; the glyph table is not cleared and entries must be written before use.
module bitmap_text_quad_layout_core #(
	parameter int GLYPH_COUNT = 128,
	parameter int ATLAS_SIZE  = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// char_code, glyph_advance, glyph_x_bearing, glyph_y_offset, glyph_width,
	// glyph_height, atlas_u, atlas_v
	input  logic [btql_pkg::IN_DATA_W-1:0] s_axis_tdata,
	// action
	input  logic [1:0]                    s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// screen_left, screen_top, screen_right, screen_bottom, tex_left, tex_top,
	// tex_right, tex_bottom, text_width, text_height, zero pad
	output logic [btql_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// quad_valid
	output logic [0:0]                    m_axis_tuser,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [2:0]                    cfg_index,
	input  logic [15:0]                   cfg_data
);
	import btql_pkg::*;

	localparam int IDX_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
	localparam logic [8:0]  GLYPH_LIMIT = 9'(GLYPH_COUNT);
	localparam logic [12:0] ATLAS_LIMIT = 13'(ATLAS_SIZE);

	// configuration
	logic [7:0]         space_width_q;
	logic [7:0]         tab_width_q;
	logic [7:0]         line_skip_q;
	logic signed [15:0] origin_x_q;
	logic signed [15:0] origin_y_q;

	// pen state
	logic [15:0] pen_x_q;
	logic [15:0] pen_y_q;
	logic [15:0] widest_q;
	logic [15:0] lines_q;

	glyph_t glyph_mem [GLYPH_COUNT];

	// input unpack
	logic [7:0] in_code;
	glyph_t     in_glyph;
	action_t    in_action;
	logic       in_table;
	logic       accept;

	// stage 1: table read data
	logic       v_s1;
	char_kind_t kind_s1;
	glyph_t     rd_s1;

	// stage 2: pen-relative sums
	logic               v_s2;
	logic               quad_s2;
	logic signed [17:0] left_s2;
	logic signed [17:0] top_s2;
	logic [7:0]         w_s2;
	logic [7:0]         h_s2;
	logic [8:0]         tl_s2;
	logic [8:0]         tt_s2;
	logic [8:0]         tr_s2;
	logic [8:0]         tb_s2;
	logic [15:0]        width_s2;
	logic [15:0]        lines_s2;

	// output register
	logic                   out_v_q;
	logic [OUT_DATA_W-1:0]  out_data_q;
	logic                   out_quad_q;

	logic ready_out;
	logic ready_s2;
	logic adv_s1;
	logic adv_s2;

	// stage 1 next-state logic
	logic [15:0]        pen_x_d;
	logic [15:0]        pen_y_d;
	logic [15:0]        widest_d;
	logic [15:0]        lines_d;
	logic [7:0]         step_x;
	logic               do_step;
	logic [15:0]        step_sum;
	logic signed [17:0] left_d;
	logic signed [17:0] top_d;

	// stage 2 to output
	logic signed [15:0] sl;
	logic signed [15:0] st;
	logic signed [15:0] sr;
	logic signed [15:0] sb;
	logic [8:0]         cl;
	logic [8:0]         ct;
	logic [8:0]         cr;
	logic [8:0]         cb;
	logic [15:0]        height_d;

	function automatic logic [8:0] clamp_atlas(input logic [8:0] v);
		clamp_atlas = ({4'b0, v} > ATLAS_LIMIT) ? ATLAS_LIMIT[8:0] : v;
	endfunction

	assign in_code   = s_axis_tdata[7:0];
	assign in_glyph  = glyph_t'({s_axis_tdata[15:8], s_axis_tdata[23:16],
		s_axis_tdata[31:24], s_axis_tdata[39:32], s_axis_tdata[47:40],
		s_axis_tdata[55:48], s_axis_tdata[63:56]});
	assign in_action = action_t'(s_axis_tuser);
	assign in_table  = {1'b0, in_code} < GLYPH_LIMIT;

	assign ready_out     = !out_v_q || m_axis_tready;
	assign ready_s2      = !v_s2 || ready_out;
	assign adv_s2        = v_s2 && ready_out;
	assign adv_s1        = v_s1 && ready_s2;
	assign s_axis_tready = !v_s1 || ready_s2;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			space_width_q <= '0;
			tab_width_q   <= '0;
			line_skip_q   <= '0;
			origin_x_q    <= '0;
			origin_y_q    <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_SPACE_WIDTH: space_width_q <= cfg_data[7:0];
				CFG_TAB_WIDTH:   tab_width_q   <= cfg_data[7:0];
				CFG_LINE_SKIP:   line_skip_q   <= cfg_data[7:0];
				CFG_ORIGIN_X:    origin_x_q    <= cfg_data;
				CFG_ORIGIN_Y:    origin_y_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// table write and read share the accept edge, so a read always sees earlier writes
	always_ff @(posedge clk) begin
		if (accept && in_action == ACT_WRITE_GLYPH && in_table) begin
			glyph_mem[in_code[IDX_W-1:0]] <= in_glyph;
		end
		if (accept && in_action == ACT_LAYOUT && in_table) begin
			rd_s1 <= glyph_mem[in_code[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			kind_s1 <= KIND_NONE;
		end else if (accept) begin
			v_s1 <= (in_action == ACT_BEGIN) || (in_action == ACT_LAYOUT);
			if (in_action == ACT_BEGIN) begin
				kind_s1 <= KIND_BEGIN;
			end else if (in_code == CH_SPACE) begin
				kind_s1 <= KIND_SPACE;
			end else if (in_code == CH_TAB) begin
				kind_s1 <= KIND_TAB;
			end else if (in_code == CH_NEWLINE) begin
				kind_s1 <= KIND_NEWLINE;
			end else if (in_table) begin
				kind_s1 <= KIND_GLYPH;
			end else begin
				kind_s1 <= KIND_NONE;
			end
		end else if (adv_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_comb begin
		case (kind_s1)
			KIND_SPACE: step_x = space_width_q;
			KIND_TAB:   step_x = tab_width_q;
			default:    step_x = rd_s1.advance;
		endcase
		do_step  = (kind_s1 == KIND_SPACE) || (kind_s1 == KIND_TAB) ||
			(kind_s1 == KIND_GLYPH);
		step_sum = sat_u16({1'b0, pen_x_q} + {9'b0, step_x});

		pen_x_d  = pen_x_q;
		pen_y_d  = pen_y_q;
		widest_d = widest_q;
		lines_d  = lines_q;
		case (kind_s1)
			KIND_BEGIN: begin
				pen_x_d  = '0;
				pen_y_d  = '0;
				widest_d = '0;
				lines_d  = '0;
			end
			KIND_NEWLINE: begin
				pen_x_d = '0;
				pen_y_d = sat_u16({1'b0, pen_y_q} + {9'b0, line_skip_q});
				lines_d = sat_u16({1'b0, lines_q} + {9'b0, line_skip_q});
			end
			default: begin
				if (do_step) begin
					pen_x_d  = step_sum;
					widest_d = (step_sum > widest_q) ? step_sum : widest_q;
				end
			end
		endcase

		left_d = {{2{origin_x_q[15]}}, origin_x_q} +
			{{10{rd_s1.x_bearing[7]}}, rd_s1.x_bearing} + {2'b00, pen_x_q};
		top_d  = {{2{origin_y_q[15]}}, origin_y_q} +
			{{10{rd_s1.y_offset[7]}}, rd_s1.y_offset} + {2'b00, pen_y_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q  <= '0;
			pen_y_q  <= '0;
			widest_q <= '0;
			lines_q  <= '0;
			v_s2     <= 1'b0;
		end else begin
			if (adv_s1) begin
				pen_x_q  <= pen_x_d;
				pen_y_q  <= pen_y_d;
				widest_q <= widest_d;
				lines_q  <= lines_d;
				v_s2     <= (kind_s1 != KIND_BEGIN);
			end else if (adv_s2) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			quad_s2  <= (kind_s1 == KIND_GLYPH) && (rd_s1.width != '0) &&
				(rd_s1.height != '0);
			left_s2  <= left_d;
			top_s2   <= top_d;
			w_s2     <= rd_s1.width;
			h_s2     <= rd_s1.height;
			tl_s2    <= {1'b0, rd_s1.atlas_u};
			tt_s2    <= {1'b0, rd_s1.atlas_v};
			tr_s2    <= {1'b0, rd_s1.atlas_u} + {1'b0, rd_s1.width};
			tb_s2    <= {1'b0, rd_s1.atlas_v} + {1'b0, rd_s1.height};
			width_s2 <= widest_d;
			lines_s2 <= lines_d;
		end
	end

	always_comb begin
		sl       = sat_s16({left_s2[17], left_s2});
		st       = sat_s16({top_s2[17], top_s2});
		sr       = sat_s16({left_s2[17], left_s2} + {11'b0, w_s2});
		sb       = sat_s16({top_s2[17], top_s2} + {11'b0, h_s2});
		cl       = clamp_atlas(tl_s2);
		ct       = clamp_atlas(tt_s2);
		cr       = clamp_atlas(tr_s2);
		cb       = clamp_atlas(tb_s2);
		height_d = sat_u16({1'b0, lines_s2} + {9'b0, line_skip_q});
		if (!quad_s2) begin
			sl = '0;
			st = '0;
			sr = '0;
			sb = '0;
			cl = '0;
			ct = '0;
			cr = '0;
			cb = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (ready_out) begin
			out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			out_quad_q <= quad_s2;
			out_data_q <= {4'b0, height_d, width_s2, cb, cr, ct, cl, sb, sr, st, sl};
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_quad_q;

endmodule
